// File: hdl/jtd_pkg.sv
// Shared types, register codes and constants of the headset jack type detector.
`default_nettype none

package jtd_pkg;

    localparam int ZONES          = 4;
    localparam int HW_ZONES       = 4;
    localparam int DEBOUNCE_TICKS = 200;
    localparam int ZONE_LIMIT     = (ZONES < HW_ZONES) ? ZONES : HW_ZONES;
    localparam int ZONE_IDX_W     = $clog2(HW_ZONES);

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 36;
    localparam int IN_TDATA_W  = 16;
    localparam int OUT_TDATA_W = 16;

    localparam logic [CFG_INDEX_W-1:0] REG_ZONE_A        = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_ZONE_B        = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_ZONE_C        = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_ZONE_D        = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_ZONE_COUNT    = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_DETECT_POLAR  = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] REG_HEADSET_CODE  = 3'd6;

    localparam logic [8:0] HITS_MAX       = 9'd511;
    localparam logic [7:0] DEBOUNCE_LOAD  = 8'(DEBOUNCE_TICKS);
    localparam logic [7:0] HEADSET_RESET  = 8'd3;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_DEBOUNCE,
        PH_SAMPLE,
        PH_WAIT
    } phase_t;

    typedef struct packed {
        logic [7:0]  kind;
        logic [7:0]  delay_ticks;
        logic [7:0]  confirm;
        logic [11:0] upper;
    } zone_t;

    typedef struct packed {
        zone_t [HW_ZONES-1:0] zones;
        logic [2:0]           zone_count;
        logic                 detect_active_high;
        logic [7:0]           headset_code;
    } cfg_t;

    typedef struct packed {
        logic        restart;
        logic [11:0] adc_sample;
        logic        detect_level;
    } item_t;

    typedef struct packed {
        logic       busy_res;
        logic       type_changed;
        logic [7:0] jack_kind;
        logic       key_detect_on;
        logic       mic_bias;
    } result_t;

endpackage

`default_nettype wire

// File: hdl/jtd_cfg.sv
// Configuration register file: zone table, zone count, detect polarity, headset code.
`default_nettype none

module jtd_cfg (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic                               wr_en,
    input  wire logic [jtd_pkg::CFG_INDEX_W-1:0]    wr_index,
    input  wire logic [jtd_pkg::CFG_DATA_W-1:0]     wr_data,
    output jtd_pkg::cfg_t                           cfg
);
    import jtd_pkg::*;

    zone_t [HW_ZONES-1:0] zones_reg;
    logic [2:0]           zone_count_reg;
    logic                 polarity_reg;
    logic [7:0]           headset_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            zones_reg      <= '0;
            zone_count_reg <= '0;
            polarity_reg   <= 1'b1;
            headset_reg    <= HEADSET_RESET;
        end else if (wr_en) begin
            case (wr_index)
                REG_ZONE_A:       zones_reg[0]   <= zone_t'(wr_data);
                REG_ZONE_B:       zones_reg[1]   <= zone_t'(wr_data);
                REG_ZONE_C:       zones_reg[2]   <= zone_t'(wr_data);
                REG_ZONE_D:       zones_reg[3]   <= zone_t'(wr_data);
                REG_ZONE_COUNT:   zone_count_reg <= wr_data[2:0];
                REG_DETECT_POLAR: polarity_reg   <= wr_data[0];
                REG_HEADSET_CODE: headset_reg    <= wr_data[7:0];
                default: ;
            endcase
        end
    end

    assign cfg.zones              = zones_reg;
    assign cfg.zone_count         = zone_count_reg;
    assign cfg.detect_active_high = polarity_reg;
    assign cfg.headset_code       = headset_reg;

endmodule

`default_nettype wire

// File: hdl/jtd_step.sv
// Detection state and the per-tick update: debounce, zone classification, type reporting.
`default_nettype none

module jtd_step (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              advance,
    input  jtd_pkg::item_t         item,
    input  jtd_pkg::cfg_t          cfg,
    output jtd_pkg::result_t       result
);
    import jtd_pkg::*;

    phase_t     phase_reg, phase_next;
    logic [7:0] debounce_reg, debounce_next;
    logic [7:0] wait_reg, wait_next;
    logic [8:0] hits_reg [HW_ZONES];
    logic [8:0] hits_next [HW_ZONES];
    logic [7:0] kind_reg, kind_next;
    logic       bias_reg, bias_next;
    logic       keys_reg, keys_next;
    logic       changed;

    logic                  present;
    logic [2:0]            zones_used;
    logic                  found;
    logic [ZONE_IDX_W-1:0] sel;
    logic [8:0]            hit_inc;
    zone_t                 zsel;

    assign present    = (item.detect_level == cfg.detect_active_high);
    assign zones_used = (cfg.zone_count > 3'(ZONE_LIMIT)) ? 3'(ZONE_LIMIT) : cfg.zone_count;

    always_comb begin
        found = 1'b0;
        sel   = '0;
        for (int i = 0; i < HW_ZONES; i++) begin
            if (!found && (3'(i) < zones_used) && (item.adc_sample <= cfg.zones[i].upper)) begin
                found = 1'b1;
                sel   = ZONE_IDX_W'(i);
            end
        end
    end

    assign zsel = cfg.zones[sel];

    always_comb begin
        phase_next    = phase_reg;
        debounce_next = debounce_reg;
        wait_next     = wait_reg;
        hits_next     = hits_reg;
        kind_next     = kind_reg;
        bias_next     = bias_reg;
        keys_next     = keys_reg;
        changed       = 1'b0;
        hit_inc       = '0;

        if (item.restart) begin
            bias_next     = 1'b1;
            hits_next     = '{default: '0};
            debounce_next = DEBOUNCE_LOAD;
            wait_next     = '0;
            phase_next    = PH_DEBOUNCE;
        end

        if (phase_next != PH_IDLE && !present) begin
            // removal: report nothing inserted
            bias_next = 1'b0;
            if (kind_next != '0) begin
                keys_next = (cfg.headset_code == '0);
                kind_next = '0;
                changed   = 1'b1;
            end
            phase_next = PH_IDLE;
        end else begin
            case (phase_next)
                PH_DEBOUNCE: begin
                    if (debounce_next != '0) debounce_next = debounce_next - 8'd1;
                    if (debounce_next == '0) phase_next = PH_SAMPLE;
                end
                PH_WAIT: begin
                    if (wait_next != '0) wait_next = wait_next - 8'd1;
                    if (wait_next == '0) phase_next = PH_SAMPLE;
                end
                PH_SAMPLE: begin
                    if (found) begin
                        hit_inc = (hits_next[sel] == HITS_MAX) ? HITS_MAX : hits_next[sel] + 9'd1;
                        hits_next[sel] = hit_inc;
                        if (hit_inc > {1'b0, zsel.confirm}) begin
                            if (zsel.kind == kind_next) begin
                                if (zsel.kind != cfg.headset_code) bias_next = 1'b0;
                            end else begin
                                if (zsel.kind == cfg.headset_code) begin
                                    keys_next = 1'b1;
                                end else begin
                                    keys_next = 1'b0;
                                    bias_next = 1'b0;
                                end
                                kind_next = zsel.kind;
                                changed   = 1'b1;
                            end
                            phase_next = PH_IDLE;
                        end else begin
                            wait_next  = zsel.delay_ticks;
                            phase_next = (zsel.delay_ticks == '0) ? PH_SAMPLE : PH_WAIT;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    always_comb begin
        result.mic_bias      = bias_next;
        result.key_detect_on = keys_next;
        result.jack_kind     = kind_next;
        result.type_changed  = changed;
        result.busy_res      = (phase_next != PH_IDLE);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg    <= PH_IDLE;
            debounce_reg <= '0;
            wait_reg     <= '0;
            hits_reg     <= '{default: '0};
            kind_reg     <= '0;
            bias_reg     <= 1'b0;
            keys_reg     <= 1'b0;
        end else if (advance) begin
            phase_reg    <= phase_next;
            debounce_reg <= debounce_next;
            wait_reg     <= wait_next;
            hits_reg     <= hits_next;
            kind_reg     <= kind_next;
            bias_reg     <= bias_next;
            keys_reg     <= keys_next;
        end
    end

endmodule

`default_nettype wire

// File: hdl/headset_jack_type_detector_top.sv
// Top level of the headset jack type detector: stream stages, config port, detection core.
`default_nettype none

// One transaction on s_ is one 1 ms tick; each tick yields exactly one result transaction on
// m_. A tick is registered on entry, processed against the detection state and written into
// the output register; a new tick is taken every cycle while m_tready is high. The throughput
// limit is the combinational state update (zone compare, hit count, type rules). Configuration
// writes on cfg_ are always accepted and must be issued only while no tick is in flight.
module headset_jack_type_detector_top (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                s_tvalid,
    output      logic                                s_tready,
    // [0] detect_level, [12:1] adc_sample, [13] restart, [15:14] zero
    input  wire logic [jtd_pkg::IN_TDATA_W-1:0]      s_tdata,
    output      logic                                m_tvalid,
    input  wire logic                                m_tready,
    // [0] mic_bias, [1] key_detect_on, [9:2] jack_kind, [10] type_changed,
    // [11] busy_res, [15:12] zero
    output      logic [jtd_pkg::OUT_TDATA_W-1:0]     m_tdata,
    input  wire logic                                cfg_valid,
    output      logic                                cfg_ready,
    input  wire logic [jtd_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  wire logic [jtd_pkg::CFG_DATA_W-1:0]      cfg_data
);
    import jtd_pkg::*;

    logic    in_valid_reg;
    item_t   in_item_reg;
    logic    out_valid_reg;
    result_t out_result_reg;
    logic    advance;
    cfg_t    cfg;
    result_t result;

    assign advance   = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready  = !in_valid_reg || advance;
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_item_reg <= item_t'(s_tdata[13:0]);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_result_reg <= result;
        end
    end

    jtd_cfg u_cfg (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_en    (cfg_valid && cfg_ready),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    jtd_step u_step (
        .aclk    (aclk),
        .aresetn (aresetn),
        .advance (advance),
        .item    (in_item_reg),
        .cfg     (cfg),
        .result  (result)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'b0, out_result_reg};

endmodule

`default_nettype wire

// File: hdl/jtd_checker.sv
// Port-level checks of the headset jack type detector and their bind to the top level.
`default_nettype none

module jtd_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_tready,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [15:0] m_tdata
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    // with an empty output register the input side never stalls
    a_no_false_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input stalled with empty output");

    // a type is reported only when detection finishes
    a_change_ends_detect: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[10] |-> !m_tdata[11])
        else $error("type change while detection busy");

endmodule

bind headset_jack_type_detector_top jtd_checker u_jtd_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire
